@@ rtl/core/csx_pkg.sv @@
// Shared types and constants for the call stack exclusive-time profiler.
// Depends on nothing; every other file of the block imports it.
package csx_pkg;

  localparam int ID_W     = 4;
  localparam int TS_W     = 32;
  localparam int ID_COUNT = 2 ** ID_W;
  localparam int CHARGE_W = TS_W + 1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  // One call stack entry: function id and the time it last resumed
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [TS_W-1:0] resume;
  } stack_entry_t;

  // Table update request passed from the stack stage to the totals stage
  typedef struct packed {
    logic [ID_W-1:0]     touched;
    logic [CHARGE_W-1:0] charge;
    logic                add;
    status_t             status;
  } charge_req_t;

endpackage

@@ rtl/core/csx_if.sv @@
// Valid/ready channel interfaces for events in and results out.
// Depends on csx_pkg for field widths.
interface csx_event_if import csx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            action;
  logic [ID_W-1:0] func_id;
  logic [TS_W-1:0] timestamp;

  modport source (output valid, action, func_id, timestamp, input ready);
  modport sink   (input valid, action, func_id, timestamp, output ready);
endinterface

interface csx_result_if import csx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] touched_id;
  logic [TS_W-1:0] total_time;
  logic [1:0]      status;

  modport source (output valid, touched_id, total_time, status, input ready);
  modport sink   (input valid, touched_id, total_time, status, output ready);
endinterface

@@ rtl/core/csx_stack.sv @@
// Event input register and call stack: top two entries in registers, the rest
// in a memory with a prefetched third entry. Depends on csx_pkg and csx_if.
module csx_stack import csx_pkg::*; #(
  parameter int MAX_FUNCS   = 16,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  csx_event_if.sink   evt,
  output logic        req_valid,
  output charge_req_t req
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Id reduction table, fixed at elaboration
  logic [ID_W-1:0] id_map [ID_COUNT];
  for (genvar g = 0; g < ID_COUNT; g++) begin : g_id_map
    assign id_map[g] = ID_W'(g % MAX_FUNCS);
  end

  logic            s1_valid;
  logic            s1_action;
  logic [ID_W-1:0] s1_id;
  logic [TS_W-1:0] s1_ts;

  logic [CW-1:0]   count;
  stack_entry_t    top;
  stack_entry_t    below;
  stack_entry_t    third_hold;
  stack_entry_t    third_q;
  logic            third_from_mem;
  stack_entry_t    third;
  stack_entry_t    stk_mem [STACK_DEPTH];

  logic            full;
  logic            empty;
  logic            do_push;
  logic            do_pop;
  logic [TS_W-1:0] elapsed;
  logic [TS_W-1:0] ts_inc;
  logic [AW-1:0]   wr_idx;
  logic [AW-1:0]   rd_idx;
  logic            wr_en;

  // Accept a new request whenever the input register is free or moving on
  assign evt.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s1_action <= evt.action;
      s1_id     <= id_map[evt.func_id];
      s1_ts     <= evt.timestamp;
    end
  end

  // Stack condition and time arithmetic for the held request
  assign full    = (count == CW'(STACK_DEPTH));
  assign empty   = (count == '0);
  assign elapsed = (s1_ts >= top.resume) ? (s1_ts - top.resume) : '0;
  assign ts_inc  = (s1_ts == '1) ? s1_ts : (s1_ts + TS_W'(1));
  assign third   = third_from_mem ? third_q : third_hold;

  always_comb begin
    req.touched = s1_id;
    req.charge  = '0;
    req.add     = 1'b0;
    req.status  = STATUS_OK;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    priority if (!s1_action && full) begin
      req.status = STATUS_OVERFLOW;
    end else if (!s1_action && empty) begin
      do_push = 1'b1;
    end else if (!s1_action) begin
      req.touched = top.id;
      req.charge  = {1'b0, elapsed};
      req.add     = 1'b1;
      do_push     = 1'b1;
    end else if (empty) begin
      req.touched = '0;
      req.status  = STATUS_UNDERFLOW;
    end else begin
      req.touched = top.id;
      req.charge  = {1'b0, elapsed} + CHARGE_W'(1);
      req.add     = 1'b1;
      do_pop      = 1'b1;
    end
  end

  assign req_valid = s1_valid;

  // Memory holds entries below the second; push spills the second entry down
  assign wr_idx = AW'({1'b0, count} - (CW + 1)'(2));
  assign rd_idx = AW'({1'b0, count} - (CW + 1)'(4));
  assign wr_en  = s1_valid && adv && do_push && ({1'b0, count} >= (CW + 1)'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      third_from_mem <= 1'b0;
    end else if (s1_valid && adv) begin
      if (do_push) begin
        count          <= count + CW'(1);
        third_from_mem <= 1'b0;
      end else if (do_pop) begin
        count          <= count - CW'(1);
        third_from_mem <= 1'b1;
      end
    end
  end

  // Advance the cached top, second and third entries
  always_ff @(posedge clk) begin
    if (s1_valid && adv) begin
      if (do_push) begin
        top.id      <= s1_id;
        top.resume  <= s1_ts;
        below.id    <= top.id;
        below.resume <= s1_ts;
        third_hold  <= below;
      end else if (do_pop) begin
        top.id      <= below.id;
        top.resume  <= ts_inc;
        below       <= third;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stk_mem[wr_idx] <= below;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && adv && do_pop) begin
      third_q <= stk_mem[rd_idx];
    end
  end

endmodule

@@ rtl/core/csx_totals.sv @@
// Exclusive-time table with saturating update, write-to-read forwarding and
// the result register. Depends on csx_pkg and csx_if.
module csx_totals import csx_pkg::*; #(
  parameter int MAX_FUNCS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        req_valid,
  input  charge_req_t req,
  csx_result_if.source res
);

  localparam int TW = (MAX_FUNCS > 1) ? $clog2(MAX_FUNCS) : 1;

  logic            s2_valid;
  charge_req_t     s2;
  logic [TS_W-1:0] tot_mem [MAX_FUNCS];
  logic            written [MAX_FUNCS];
  logic [TS_W-1:0] ram_q;
  logic            written_q;
  logic            fwd_sel;
  logic [TS_W-1:0] fwd_val;

  logic [TS_W-1:0] old_total;
  logic [TS_W+1:0] sum;
  logic [TS_W-1:0] new_total;
  logic [TW-1:0]   rd_addr;
  logic [TW-1:0]   wr_addr;
  logic            wr_en;

  assign rd_addr = TW'(req.touched);
  assign wr_addr = TW'(s2.touched);
  assign wr_en   = adv && s2_valid && s2.add;

  // Current total: forwarded value, stored value, or zero if never written
  assign old_total = fwd_sel ? fwd_val : (written_q ? ram_q : '0);
  assign sum       = {2'b00, old_total} + {1'b0, s2.charge};
  assign new_total = (sum[TS_W+1:TS_W] != 2'b00) ? '1 : sum[TS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= req_valid;
    end
  end

  // Hold the request and its table read until the pipeline moves
  always_ff @(posedge clk) begin
    if (adv) begin
      s2        <= req;
      ram_q     <= tot_mem[rd_addr];
      written_q <= written[rd_addr];
      fwd_sel   <= wr_en && (wr_addr == rd_addr);
      fwd_val   <= new_total;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tot_mem[wr_addr] <= new_total;
    end
  end

  // Mark entries once written; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FUNCS; i++) begin
        written[i] <= 1'b0;
      end
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.touched_id <= s2.touched;
      res.status     <= s2.status;
      if (s2.status == STATUS_UNDERFLOW) begin
        res.total_time <= '0;
      end else if (s2.add) begin
        res.total_time <= new_total;
      end else begin
        res.total_time <= old_total;
      end
    end
  end

endmodule

@@ rtl/core/call_stack_exclusive_time_top.sv @@
// Channel  Dir  Fields
// evt      in   action, func_id, timestamp
// res      out  touched_id, total_time, status
//
// One event per cycle sustained while results are taken. A request is
// taken into the input/stack register, its table read is registered with
// it in the totals stage, and the result register loads from there.
// The stack top and the table entry for each event are forwarded between
// neighbouring events, so back-to-back events never wait on one another.
// A stalled result holds the whole pipeline; rst clears counts and flags.
// Top level of the call stack exclusive-time profiler.
// Depends on csx_pkg, csx_if, csx_stack and csx_totals.
module call_stack_exclusive_time_top import csx_pkg::*; #(
  parameter int MAX_FUNCS   = 16,
  parameter int STACK_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  csx_event_if.sink    evt,
  csx_result_if.source res
);

  logic        adv;
  logic        req_valid;
  charge_req_t req;

  // Advance the pipeline whenever the result register is free or taken
  assign adv = !res.valid || res.ready;

  csx_stack #(
    .MAX_FUNCS   (MAX_FUNCS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .evt       (evt),
    .req_valid (req_valid),
    .req       (req)
  );

  csx_totals #(
    .MAX_FUNCS (MAX_FUNCS)
  ) u_totals (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req),
    .res       (res)
  );

endmodule
